// ===== sv/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/uetr_pkg.sv =====
package uetr_pkg;

   localparam int TIME_W = 64;
   localparam int CSR_W  = 32;
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 4;
   localparam int CSR_IDX_W = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE_BIT_TIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_OFFSET    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LENGTH     = 2'd2;

   localparam logic [CSR_W-1:0] INVERSE_BIT_TIME_RST = 32'd494780;
   localparam logic [CSR_W-1:0] SAMPLE_OFFSET_RST    = 32'd4340;
   localparam logic [CSR_W-1:0] FRAME_LENGTH_RST     = 32'd82460;

   localparam logic [IDX_W-1:0] IDX_MAX    = 4'd15;
   localparam logic [IDX_W-1:0] IDX_STOP   = 4'd8;
   localparam logic [IDX_W-1:0] IDX_REARM  = 4'd9;

   typedef enum logic {
      RX_IDLE,
      RX_FRAME
   } rx_state_type;

endpackage

// ===== sv/edge_timed_uart_receiver.sv =====
// Edge-timed 8N1 UART receiver.
// req_ channel: one word per line event. req_mode 0 is a line edge with its new
// level on req_line_high, req_mode 1 is a timeout poll; req_timestamp_ns is the
// event time. rsp_ channel: one received byte on rsp_data_byte, LSB first.
// csr_ port: write csr_write_data to register csr_index while csr_write_enable
// is high (0 inverse bit time, 1 sample offset, 2 frame length).
// An accepted word is held in the input register and decoded from there; a
// byte it completes goes to the output register and is offered on rsp_.
// Throughput: one word per cycle unless a word is stalled. The decode holds
// the 64-bit elapsed time subtract, a 32x32 and a 4x32 multiply for the bit
// index and the byte mask. Stall: a held byte on rsp_ blocks only words that
// would produce another byte; such a word waits in the input register and
// req_stall rises behind it. Words that produce no byte keep flowing.
// Reset (synchronous): idle, line assumed high, registers to their defaults,
// both stages empty.
`include "assert_macros.svh"

module edge_timed_uart_receiver
   import uetr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode,
   input  logic                  req_line_high,
   input  logic [TIME_W-1:0]     req_timestamp_ns,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BYTE_W-1:0]     rsp_data_byte,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_write_data
);

   // configuration
   logic [CSR_W-1:0] inv_bit_time_ff;
   logic [CSR_W-1:0] sample_offset_ff;
   logic [CSR_W-1:0] frame_length_ff;

   // input register
   logic              s1_valid_ff;
   logic              s1_mode_ff;
   logic              s1_high_ff;
   logic [TIME_W-1:0] s1_time_ff;

   // receiver state
   rx_state_type      state_ff, state_in;
   logic [IDX_W-1:0]  next_bit_index_ff, next_bit_index_in;
   logic              last_level_ff, last_level_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [TIME_W-1:0] frame_start_ff, frame_start_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;

   logic              s1_advance;
   logic              out_free;
   logic              req_take;

   // decode
   logic [TIME_W-1:0]     diff;
   logic                  negative;
   logic [2*CSR_W-1:0]    prod_lo;
   logic [CSR_W+IDX_W-1:0] prod_hi;
   logic [CSR_W+IDX_W:0]  idx_sum;
   logic [IDX_W-1:0]      cur;
   logic [IDX_W-1:0]      fill_to;
   logic [BYTE_W-1:0]     fill_mask;
   logic [BYTE_W-1:0]     filled;
   logic                  poll_done;
   logic                  edge_start;
   logic                  edge_stop;
   logic                  emit;
   logic                  restart;

   // ---------------------------------------------------------------
   // bit index and event decode
   always_comb begin
      diff     = s1_time_ff - frame_start_ff;
      negative = diff[TIME_W-1];
      prod_lo  = {{CSR_W{1'b0}}, diff[CSR_W-1:0]} * {{CSR_W{1'b0}}, inv_bit_time_ff};
      prod_hi  = {{CSR_W{1'b0}}, diff[CSR_W+IDX_W-1:CSR_W]}
                 * {{IDX_W{1'b0}}, inv_bit_time_ff};
      idx_sum  = {1'b0, prod_hi} + {{(IDX_W+1){1'b0}}, prod_lo[2*CSR_W-1:CSR_W]};

      priority if (inv_bit_time_ff == '0 || negative) begin
         cur = '0;
      end else if (diff[TIME_W-1:CSR_W+IDX_W] != '0) begin
         cur = IDX_MAX;
      end else if (idx_sum > {{(CSR_W+1){1'b0}}, IDX_MAX}) begin
         cur = IDX_MAX;
      end else begin
         cur = idx_sum[IDX_W-1:0];
      end

      poll_done  = s1_mode_ff && (state_ff == RX_FRAME) && !negative
                   && (diff >= {{(TIME_W-CSR_W){1'b0}}, frame_length_ff});
      edge_start = !s1_mode_ff && (state_ff == RX_IDLE) && !s1_high_ff;
      edge_stop  = !s1_mode_ff && (state_ff == RX_FRAME) && (cur >= IDX_STOP);

      emit    = (poll_done && last_level_ff)
                || (edge_stop && (s1_high_ff || last_level_ff));
      restart = edge_stop && emit && !s1_high_ff && (cur >= IDX_REARM);
   end

   // fill the bits since the last edge with the previous level
   always_comb begin
      fill_to = s1_mode_ff ? IDX_STOP : cur;
      for (int i = 0; i < BYTE_W; i++) begin
         fill_mask[i] = (IDX_W'(i) >= next_bit_index_ff) && (IDX_W'(i) < fill_to);
      end
      filled = byte_ff | (last_level_ff ? fill_mask : '0);
   end

   // ---------------------------------------------------------------
   // handshake
   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      s1_advance = s1_valid_ff && (out_free || !emit);
      req_stall  = s1_valid_ff && !s1_advance;
      req_take   = req_valid && !req_stall;
   end

   // ---------------------------------------------------------------
   // next state
   always_comb begin
      state_in = state_ff;
      if (s1_advance) begin
         priority if (edge_start || restart) begin
            state_in = RX_FRAME;
         end else if (poll_done || edge_stop) begin
            state_in = RX_IDLE;
         end else begin
            state_in = state_ff;
         end
      end
   end

   // datapath updates
   always_comb begin
      next_bit_index_in = next_bit_index_ff;
      last_level_in     = last_level_ff;
      byte_in           = byte_ff;
      frame_start_in    = frame_start_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_data_in       = rsp_data_ff;

      if (s1_advance) begin
         if (emit) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = filled;
         end
         priority if (edge_start || restart) begin
            next_bit_index_in = '0;
            byte_in           = '0;
            last_level_in     = 1'b0;
            frame_start_in    = s1_time_ff + {{(TIME_W-CSR_W){1'b0}}, sample_offset_ff};
         end else if (poll_done) begin
            byte_in = filled;
         end else if (edge_stop) begin
            byte_in       = filled;
            last_level_in = s1_high_ff;
         end else if (!s1_mode_ff && state_ff == RX_FRAME) begin
            // set the bit under the edge when the line rose
            byte_in = filled | (s1_high_ff ? (BYTE_W'(1) << cur[2:0]) : '0);
            next_bit_index_in = cur + IDX_W'(1);
            last_level_in     = s1_high_ff;
         end else begin
            byte_in = byte_ff;
         end
      end
   end

   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_bit_time_ff   <= INVERSE_BIT_TIME_RST;
         sample_offset_ff  <= SAMPLE_OFFSET_RST;
         frame_length_ff   <= FRAME_LENGTH_RST;
         s1_valid_ff       <= 1'b0;
         state_ff          <= RX_IDLE;
         next_bit_index_ff <= '0;
         last_level_ff     <= 1'b1;
         byte_ff           <= '0;
         frame_start_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_INVERSE_BIT_TIME: inv_bit_time_ff  <= csr_write_data;
               CSR_SAMPLE_OFFSET:    sample_offset_ff <= csr_write_data;
               CSR_FRAME_LENGTH:     frame_length_ff  <= csr_write_data;
               default:              ;
            endcase
         end
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         state_ff          <= state_in;
         next_bit_index_ff <= next_bit_index_in;
         last_level_ff     <= last_level_in;
         byte_ff           <= byte_in;
         frame_start_ff    <= frame_start_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload: load the word when taken, and the output byte from rsp_data_in
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff <= req_mode;
         s1_high_ff <= req_line_high;
         s1_time_ff <= req_timestamp_ns;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_byte = rsp_data_ff;

   // ---------------------------------------------------------------
   `ASSERT_CLK(a_bit_index_range, clock, reset, next_bit_index_ff <= IDX_STOP, "bit index past stop bit")
   `ASSERT_CLK(a_rsp_from_decode, clock, reset, !rsp_valid_ff ##1 rsp_valid_ff |-> $past(s1_advance), "byte appeared without a decoded word")
   `ASSERT_CLK(a_held_word_kept, clock, reset, s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_time_ff), "waiting word lost")
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> state_ff == RX_IDLE && !rsp_valid_ff && !s1_valid_ff, "not idle after reset")

endmodule

// ===== tb/edge_timed_uart_receiver_tb.sv =====
`timescale 1ns / 100ps

module edge_timed_uart_receiver_tb;
   import uetr_pkg::*;

   localparam logic MODE_EDGE = 1'b0;
   localparam logic MODE_POLL = 1'b1;

   localparam longint unsigned DEF_BIT_NS = 8680;
   localparam int unsigned LONG_HOLD_AT = 400;
   localparam int unsigned LONG_HOLD_CYCLES = 400;
   localparam int unsigned DRAIN_LIMIT = 4000;
   localparam int unsigned PIPE_SETTLE = 4;
   localparam int unsigned TIMEOUT_CYCLES = 500000;

   typedef struct packed {
      logic              mode;
      logic              line_high;
      logic [TIME_W-1:0] timestamp_ns;
   } line_word_type;

   typedef enum {
      FRAME_END_NONE,
      FRAME_END_LATE_POLL,
      FRAME_END_BOTH_POLLS
   } frame_end_type;

   typedef enum {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_style_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_mode = MODE_EDGE;
   logic                 req_line_high = 1'b1;
   logic [TIME_W-1:0]    req_timestamp_ns = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [BYTE_W-1:0]    rsp_data_byte;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_INVERSE_BIT_TIME;
   logic [CSR_W-1:0]     csr_write_data = '0;

   edge_timed_uart_receiver uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_line_high    (req_line_high),
      .req_timestamp_ns (req_timestamp_ns),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data_byte    (rsp_data_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // decoder copy: registers and frame state
   logic [CSR_W-1:0]    inv_bit_time = INVERSE_BIT_TIME_RST;
   logic [CSR_W-1:0]    half_bit_ns = SAMPLE_OFFSET_RST;
   logic [CSR_W-1:0]    frame_length = FRAME_LENGTH_RST;
   rx_state_type        rx_state = RX_IDLE;
   logic [IDX_W-1:0]    rx_bit_pos = '0;
   logic                line_level = 1'b1;
   logic [BYTE_W-1:0]   byte_acc = '0;
   logic [TIME_W-1:0]   origin_ns = '0;

   line_word_type       pending_words[$];
   logic [BYTE_W-1:0]   expected_bytes[$];
   line_word_type       word_on_bus;
   int unsigned         words_queued = 0;
   int unsigned         words_accepted = 0;
   int unsigned         failures = 0;
   int unsigned         burst_left = 1;
   int unsigned         gap_left = 0;
   int unsigned         hold_left = 0;
   bit                  long_hold_done = 1'b0;
   stall_style_type     stall_style = STALL_NONE;
   int unsigned         stall_phase_left = 0;
   int unsigned         cycle_count = 0;

   // stimulus timeline
   longint unsigned     bit_ns = DEF_BIT_NS;
   longint unsigned     stream_ns = 0;

   function automatic logic [IDX_W-1:0] bit_index_at(logic [TIME_W-1:0] elapsed);
      logic [95:0] product;
      product = 96'(elapsed) * 96'(inv_bit_time);
      if (product[95:32] > 64'(IDX_MAX))
         return IDX_MAX;
      return product[32 +: IDX_W];
   endfunction

   task automatic fill_with_level(input int unsigned upto);
      int unsigned i;
      for (i = rx_bit_pos; i < upto && i < 8; i++)
         if (line_level)
            byte_acc[i] = 1'b1;
   endtask

   task automatic open_frame(input logic [TIME_W-1:0] now_ns);
      rx_state = RX_FRAME;
      rx_bit_pos = '0;
      byte_acc = '0;
      line_level = 1'b0;
      origin_ns = now_ns + TIME_W'(half_bit_ns);
   endtask

   task automatic predict_word(input line_word_type w);
      logic [TIME_W-1:0] diff;
      logic              negative;
      logic [IDX_W-1:0]  cur;
      diff = w.timestamp_ns - origin_ns;
      negative = diff[TIME_W-1];
      if (w.mode == MODE_POLL) begin
         if (rx_state == RX_FRAME && !negative && diff >= TIME_W'(frame_length)) begin
            rx_state = RX_IDLE;
            if (line_level) begin
               fill_with_level(8);
               expected_bytes.push_back(byte_acc);
            end
         end
      end else if (rx_state == RX_IDLE) begin
         if (!w.line_high)
            open_frame(w.timestamp_ns);
      end else begin
         cur = negative ? '0 : bit_index_at(diff);
         fill_with_level(cur);
         if (cur >= IDX_STOP) begin
            if (w.line_high || line_level) begin
               expected_bytes.push_back(byte_acc);
               // a falling edge late enough is the next start bit
               if (!w.line_high && cur >= IDX_REARM)
                  open_frame(w.timestamp_ns);
               else
                  rx_state = RX_IDLE;
            end else begin
               rx_state = RX_IDLE;
            end
         end else begin
            if (w.line_high)
               byte_acc[cur[2:0]] = 1'b1;
            rx_bit_pos = cur + 1'b1;
         end
         line_level = w.line_high;
      end
   endtask

   task automatic push_word(input logic mode, input logic high, input logic [TIME_W-1:0] ts);
      line_word_type w;
      w.mode = mode;
      w.line_high = high;
      w.timestamp_ns = ts;
      pending_words.push_back(w);
      words_queued++;
   endtask

   function automatic longint unsigned wobble(longint unsigned span);
      return longint'($urandom_range(0, 32'(2 * span))) - span;
   endfunction

   function automatic longint unsigned up_to_a_bit();
      return longint'($urandom_range(0, 32'(bit_ns - 1)));
   endfunction

   // one 8N1 frame starting at stream_ns, edges only where the level changes
   task automatic push_frame(input logic [7:0] data, input logic stop_high,
                             input frame_end_type ending);
      longint unsigned t0, k;
      logic level, want;
      t0 = stream_ns;
      push_word(MODE_EDGE, 1'b0, t0);
      level = 1'b0;
      for (k = 1; k <= 9; k++) begin
         want = (k == 9) ? stop_high : data[k-1];
         if (want != level) begin
            push_word(MODE_EDGE, want, t0 + k * bit_ns + wobble(bit_ns / 8));
            level = want;
         end
      end
      if (ending == FRAME_END_BOTH_POLLS)
         push_word(MODE_POLL, 1'($urandom), t0 + 5 * bit_ns);
      // framing error leaves the line low: release it
      if (!level)
         push_word(MODE_EDGE, 1'b1, t0 + longint'(10 + $urandom_range(0, 2)) * bit_ns);
      if (ending != FRAME_END_NONE)
         push_word(MODE_POLL, 1'($urandom),
                   t0 + half_bit_ns + frame_length + up_to_a_bit());
      stream_ns = t0 + longint'(11 + $urandom_range(0, 3)) * bit_ns + up_to_a_bit();
   endtask

   task automatic queue_traffic(input int unsigned count);
      int unsigned stop_at, pick;
      stop_at = words_queued + count;
      while (words_queued < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            push_frame(8'($urandom), 1'b1, frame_end_type'($urandom_range(0, 2)));
         end else if (pick < 80) begin
            push_frame(8'($urandom), 1'b0, frame_end_type'($urandom_range(0, 2)));
         end else if (pick < 86) begin
            // start bit glitch
            push_word(MODE_EDGE, 1'b0, stream_ns);
            push_word(MODE_EDGE, 1'b1, stream_ns + bit_ns / 4);
            stream_ns = stream_ns + 12 * bit_ns;
         end else if (pick < 95) begin
            push_word(pick[0] ? MODE_POLL : MODE_EDGE, 1'($urandom),
                      stream_ns + longint'($urandom_range(0, 1200)) * bit_ns / 100);
            stream_ns = stream_ns + 13 * bit_ns;
         end else begin
            // close any open frame, then jump anywhere in time
            push_word(MODE_POLL, 1'b0, stream_ns + half_bit_ns + frame_length);
            stream_ns = {$urandom, $urandom};
         end
      end
      push_word(MODE_POLL, 1'b0, stream_ns + half_bit_ns + frame_length);
      stream_ns = stream_ns + half_bit_ns + frame_length + 2 * bit_ns;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_INVERSE_BIT_TIME: begin
            inv_bit_time = value;
            bit_ns = 64'h1_0000_0000 / value;
         end
         CSR_SAMPLE_OFFSET: half_bit_ns = value;
         CSR_FRAME_LENGTH: frame_length = value;
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_bit_time(input longint unsigned ns);
      write_register(CSR_INVERSE_BIT_TIME, CSR_W'(64'h1_0000_0000 / ns));
      write_register(CSR_SAMPLE_OFFSET, CSR_W'(ns / 2));
      write_register(CSR_FRAME_LENGTH, CSR_W'(ns * 19 / 2));
   endtask

   task automatic drain_results();
      int unsigned waited;
      waited = 0;
      while (words_accepted != words_queued)
         @(posedge clock);
      while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_bytes.size() != 0) begin
         $error("data_byte: %0d expected bytes never arrived", expected_bytes.size());
         failures++;
         expected_bytes.delete();
      end
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   // sender: bursts of words with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_word(word_on_bus);
            words_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0 || pending_words.size() == 0) begin
               if (gap_left != 0)
                  gap_left--;
               req_valid <= 1'b0;
            end else begin
               word_on_bus = pending_words.pop_front();
               req_valid <= 1'b1;
               req_mode <= word_on_bus.mode;
               req_line_high <= word_on_bus.line_high;
               req_timestamp_ns <= word_on_bus.timestamp_ns;
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
                  gap_left = $urandom_range(0, 10);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off to back up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!long_hold_done && words_accepted >= LONG_HOLD_AT) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_phase_left == 0) begin
            stall_style = stall_style_type'($urandom_range(0, 3));
            stall_phase_left = $urandom_range(20, 200);
         end else begin
            stall_phase_left--;
         end
         case (stall_style)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // byte checker
   always @(posedge clock) begin
      logic [BYTE_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $error("data_byte: expected none, got 0x%02h", rsp_data_byte);
            failures++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_data_byte !== want) begin
               $error("data_byte: expected 0x%02h, got 0x%02h", want, rsp_data_byte);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("edge_timed_uart_receiver_tb NOT OK");
         $finish;
      end
   end

   initial begin
      longint unsigned rearm_ns;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // idle: poll and rising edge do nothing
      push_word(MODE_POLL, 1'b0, '0);
      push_word(MODE_EDGE, 1'b1, '0);
      // frame at time zero; first edge lands before the sampling origin
      push_word(MODE_EDGE, 1'b0, '0);
      push_word(MODE_EDGE, 1'b1, 64'd100);
      push_word(MODE_EDGE, 1'b1, 4340 + 2 * DEF_BIT_NS + 2000);
      push_word(MODE_EDGE, 1'b0, 4340 + 4 * DEF_BIT_NS + 2000);
      push_word(MODE_POLL, 1'b1, 4340 + 6 * DEF_BIT_NS);
      push_word(MODE_POLL, 1'b0, 4340 + 82460);
      // origin wraps past the top of the time range; poll fills with ones
      push_word(MODE_EDGE, 1'b0, ~64'd3000);
      push_word(MODE_EDGE, 1'b1, '1);
      push_word(MODE_POLL, 1'b0, 1339 + 82460);
      // stop bit edge after all-zero data
      push_word(MODE_EDGE, 1'b0, 64'd200000);
      push_word(MODE_EDGE, 1'b1, 204340 + 8 * DEF_BIT_NS + 2000);
      // falling edge at bit 8 after a high bit: emit, then idle
      push_word(MODE_EDGE, 1'b0, 64'd300000);
      push_word(MODE_EDGE, 1'b1, 304340 + 7 * DEF_BIT_NS + 2000);
      push_word(MODE_EDGE, 1'b0, 304340 + 8 * DEF_BIT_NS + 2000);
      push_word(MODE_EDGE, 1'b1, 304340 + 9 * DEF_BIT_NS);
      // falling edge past the stop bit starts the next frame at once
      rearm_ns = 504340 + 9 * DEF_BIT_NS + 2000;
      push_word(MODE_EDGE, 1'b0, 64'd500000);
      push_word(MODE_EDGE, 1'b1, 504340 + 2000);
      push_word(MODE_EDGE, 1'b0, rearm_ns);
      // far-off edge saturates the bit index
      push_word(MODE_EDGE, 1'b1, rearm_ns + 4340 + (64'd1 << 40));
      // low at stop with low data bits: drop
      push_word(MODE_EDGE, 1'b0, 64'd1 << 41);
      push_word(MODE_EDGE, 1'b0, (64'd1 << 41) + 4340 + 8 * DEF_BIT_NS + 2000);
      stream_ns = (64'd1 << 41) + 20 * DEF_BIT_NS;
      queue_traffic(880);
      drain_results();

      // one ns per bit, sample right at the edge, any later poll ends the frame
      write_register(CSR_INVERSE_BIT_TIME, '1);
      write_register(CSR_SAMPLE_OFFSET, '0);
      write_register(CSR_FRAME_LENGTH, '0);
      queue_traffic(230);
      drain_results();

      // slowest line, origin a whole bit late, timeout after about a bit
      write_register(CSR_INVERSE_BIT_TIME, 32'd1);
      write_register(CSR_SAMPLE_OFFSET, '1);
      write_register(CSR_FRAME_LENGTH, '1);
      queue_traffic(230);
      drain_results();

      // random rate, starting just below the top of the time range
      set_bit_time(longint'($urandom_range(40, 200000)));
      stream_ns = 64'hFFFF_FFFF_FFFF_FFFF - 30 * bit_ns;
      queue_traffic(230);
      drain_results();

      set_bit_time(16);
      queue_traffic(230);
      drain_results();

      if (failures == 0)
         $display("edge_timed_uart_receiver_tb OK");
      else
         $display("edge_timed_uart_receiver_tb NOT OK");
      $finish;
   end

endmodule
